// ===== rtl/iar_pkg.sv =====
package iar_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned DATA_W         = 64;
  localparam int unsigned MODE_W         = 3;
  localparam int unsigned CHAR_W         = 8;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_OCT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HEXL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HEXU = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UDEC = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SDEC = 3'd4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    RADIX_OCT,
    RADIX_HEX,
    RADIX_DEC
  } radix_e;

  // commands from the sequencer to the digit chain
  typedef struct packed {
    logic load;   // clear digits, take new magnitude
    logic step;   // shift one magnitude bit into the chain
    logic shift;  // move digits up by one place (top digit consumed)
  } dig_cmd_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + {4'd0, d};
    end else if (upper) begin
      c = ASCII_UA + {4'd0, d} - 8'd10;
    end else begin
      c = ASCII_LA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== rtl/iar_digits.sv =====
module iar_digits #(
  parameter int unsigned VALUE_BITS = iar_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  iar_pkg::dig_cmd_t       cmd_i,
  input  iar_pkg::radix_e         radix_i,
  input  logic [VALUE_BITS-1:0]   mag_i,
  output logic [3:0]              top_digit_o
);

  localparam int unsigned OctDigits = (VALUE_BITS + 2) / 3;
  localparam int unsigned DecDigits = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned NumDigits = (OctDigits > DecDigits) ? OctDigits : DecDigits;

  logic [VALUE_BITS-1:0]  bits_q;
  logic [NumDigits-1:0][3:0] digs_q;
  logic [NumDigits-1:0][3:0] stepped;
  logic [NumDigits-1:0]      carry;
  iar_pkg::radix_e           radix_q;

  // One chain step: decimal digits take add-3 correction, octal digits are
  // 3 bits wide, hex digits shift plainly. Carry out of each digit depends
  // on that digit alone, so the loop is over independent slices.
  always_comb begin
    logic [3:0] adj;
    logic       cin;
    stepped = '0;
    carry   = '0;
    for (int i = 0; i < NumDigits; i++) begin
      adj = digs_q[i];
      if (radix_q == iar_pkg::RADIX_DEC && digs_q[i] >= 4'd5) begin
        adj = digs_q[i] + 4'd3;
      end
      cin = (i == 0) ? bits_q[VALUE_BITS-1] : carry[(i == 0) ? 0 : i-1];
      if (radix_q == iar_pkg::RADIX_OCT) begin
        carry[i]   = digs_q[i][2];
        stepped[i] = {1'b0, digs_q[i][1:0], cin};
      end else begin
        carry[i]   = adj[3];
        stepped[i] = {adj[2:0], cin};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= iar_pkg::RADIX_DEC;
    end else if (cmd_i.load) begin
      radix_q <= radix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bits_q <= mag_i;
      digs_q <= '0;
    end else if (cmd_i.step) begin
      bits_q <= {bits_q[VALUE_BITS-2:0], 1'b0};
      digs_q <= stepped;
    end else if (cmd_i.shift) begin
      digs_q <= {digs_q[NumDigits-2:0], 4'd0};
    end
  end

  assign top_digit_o = digs_q[NumDigits-1];

endmodule

// ===== rtl/iar_ctrl.sv =====
module iar_ctrl #(
  parameter int unsigned VALUE_BITS = iar_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic [iar_pkg::MODE_W-1:0]   s_mode_i,
  input  logic [iar_pkg::DATA_W-1:0]   s_value_i,
  input  logic [3:0]                   top_digit_i,
  output iar_pkg::dig_cmd_t            cmd_o,
  output iar_pkg::radix_e              radix_o,
  output logic [VALUE_BITS-1:0]        mag_o,
  output logic                         m_valid_o,
  input  logic                         m_ready_i,
  output logic [iar_pkg::CHAR_W-1:0]   m_char_o,
  output logic                         m_last_o
);

  localparam int unsigned OctDigits = (VALUE_BITS + 2) / 3;
  localparam int unsigned DecDigits = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned NumDigits = (OctDigits > DecDigits) ? OctDigits : DecDigits;
  localparam int unsigned DW        = $clog2(NumDigits);
  localparam int unsigned BW        = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_SKIP,
    S_EMIT
  } state_e;

  state_e                      state_q;
  logic [BW-1:0]               bit_cnt_q;
  logic [DW-1:0]               dig_cnt_q;
  logic                        neg_q;
  logic                        upper_q;
  logic                        m_valid_q;
  logic [iar_pkg::CHAR_W-1:0]  m_char_q;
  logic                        m_last_q;

  logic [VALUE_BITS-1:0] val;
  logic                  neg;
  logic                  accept;
  logic                  slot_free;
  logic                  emit;
  logic                  dig_last;
  logic                  top_zero;

  assign val       = s_value_i[VALUE_BITS-1:0];
  assign neg       = (s_mode_i == iar_pkg::MODE_SDEC) && val[VALUE_BITS-1];
  assign mag_o     = neg ? (~val + VALUE_BITS'(1)) : val;
  assign s_ready_o = (state_q == S_IDLE);
  assign accept    = s_ready_o && s_valid_i;
  assign slot_free = !m_valid_q || m_ready_i;
  // a new beat is loaded into the output register this cycle
  assign emit      = slot_free && ((state_q == S_SIGN) || (state_q == S_EMIT));
  assign dig_last  = (dig_cnt_q == DW'(NumDigits - 1));
  assign top_zero  = (top_digit_i == 4'd0);

  always_comb begin
    unique case (s_mode_i) inside
      iar_pkg::MODE_OCT:                    radix_o = iar_pkg::RADIX_OCT;
      iar_pkg::MODE_HEXL, iar_pkg::MODE_HEXU: radix_o = iar_pkg::RADIX_HEX;
      default:                              radix_o = iar_pkg::RADIX_DEC;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = accept;
    cmd_o.step  = (state_q == S_CONV);
    cmd_o.shift = ((state_q == S_SKIP) && top_zero && !dig_last) ||
                  ((state_q == S_EMIT) && slot_free);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
      neg_q     <= 1'b0;
      upper_q   <= 1'b0;
      m_valid_q <= 1'b0;
      m_char_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_ready_i && !emit) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_valid_i) begin
            neg_q     <= neg;
            upper_q   <= (s_mode_i == iar_pkg::MODE_HEXU);
            bit_cnt_q <= BW'(VALUE_BITS - 1);
            dig_cnt_q <= '0;
            state_q   <= S_CONV;
          end
        end
        S_CONV: begin
          bit_cnt_q <= bit_cnt_q - 1'b1;
          if (bit_cnt_q == '0) begin
            state_q <= neg_q ? S_SIGN : S_SKIP;
          end
        end
        S_SIGN: begin
          if (slot_free) begin
            m_valid_q <= 1'b1;
            m_char_q  <= iar_pkg::ASCII_MINUS;
            m_last_q  <= 1'b0;
            state_q   <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (top_zero && !dig_last) begin
            dig_cnt_q <= dig_cnt_q + 1'b1;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            m_valid_q <= 1'b1;
            m_char_q  <= iar_pkg::digit_char(top_digit_i, upper_q);
            m_last_q  <= dig_last;
            dig_cnt_q <= dig_cnt_q + 1'b1;
            if (dig_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_char_o  = m_char_q;
  assign m_last_o  = m_last_q;

endmodule

// ===== rtl/integer_to_ascii_radix_unit.sv =====
// Channel | Dir | Ports                       | Contents
// s       | in  | s_tvalid_i/s_tready_o       | tuser: mode[2:0]; tdata: value[63:0]
// m       | out | m_tvalid_o/m_tready_i       | tdata: char_code[7:0]; tlast: last
//
// Per value: accept, VALUE_BITS conversion steps (one magnitude bit shifted
// into the digit chain per cycle), a minus sign for a negative value, the
// leading zero digit places skipped one by one, then one character per beat.
// One value in flight; s_tready_o rises again once the last character is in
// the output register, so the next value overlaps that final beat.
// Output stalls hold the sequencer; rst_ni clears control state only.
module integer_to_ascii_radix_unit #(
  parameter int unsigned VALUE_BITS = iar_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [iar_pkg::DATA_W-1:0]  s_tdata_i,   // value[63:0]
  input  logic [iar_pkg::MODE_W-1:0]  s_tuser_i,   // mode[2:0]
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [iar_pkg::CHAR_W-1:0]  m_tdata_o,   // char_code[7:0]
  output logic                        m_tlast_o
);

  iar_pkg::dig_cmd_t     cmd;
  iar_pkg::radix_e       radix;
  logic [VALUE_BITS-1:0] mag;
  logic [3:0]            top_digit;

  // Sequencer: takes the value, forms the magnitude (two's complement
  // negation for a negative signed value), counts conversion steps, drops
  // leading zeros and drives the output register.
  iar_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_tvalid_i),
    .s_ready_o   (s_tready_o),
    .s_mode_i    (s_tuser_i),
    .s_value_i   (s_tdata_i),
    .top_digit_i (top_digit),
    .cmd_o       (cmd),
    .radix_o     (radix),
    .mag_o       (mag),
    .m_valid_o   (m_tvalid_o),
    .m_ready_i   (m_tready_i),
    .m_char_o    (m_tdata_o),
    .m_last_o    (m_tlast_o)
  );

  // Digit chain: bit-serial radix conversion (add-3 for decimal), then
  // shifts digits up so the most significant one reaches the top.
  iar_digits #(
    .VALUE_BITS (VALUE_BITS)
  ) u_digits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .radix_i     (radix),
    .mag_i       (mag),
    .top_digit_o (top_digit)
  );

  // once a value is taken the unit is busy until its text is produced
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !s_tready_o)
    else $error("input ready straight after accepting a value");

  // the minus sign always has digits after it
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tdata_o == iar_pkg::ASCII_MINUS) |-> !m_tlast_o)
    else $error("minus sign flagged as last character");

  // only digits, letters a-f / A-F and minus ever leave
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ((m_tdata_o >= 8'h30 && m_tdata_o <= 8'h39) ||
                    (m_tdata_o >= 8'h61 && m_tdata_o <= 8'h66) ||
                    (m_tdata_o >= 8'h41 && m_tdata_o <= 8'h46) ||
                    (m_tdata_o == iar_pkg::ASCII_MINUS)))
    else $error("illegal character code on output");

  // while the last character of a value waits, no new value's text starts
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i && s_tready_o) |=> (m_tvalid_o && m_tlast_o))
    else $error("final character lost while idle");

endmodule
